FILE: rtl/core/ubjv_pkg.sv
`default_nettype none
package ubjv_pkg;

  localparam int unsigned FRAME_BYTES = 10;
  localparam int unsigned FRAME_W     = FRAME_BYTES * 8;
  localparam int unsigned LEN_W       = 4;

  typedef enum logic [3:0] {
    REQ_NULL    = 4'd0,
    REQ_BOOL    = 4'd1,
    REQ_I8      = 4'd2,
    REQ_I16     = 4'd3,
    REQ_I32     = 4'd4,
    REQ_I64     = 4'd5,
    REQ_F32     = 4'd6,
    REQ_F64     = 4'd7,
    REQ_STRHDR  = 4'd8,
    REQ_STRCHAR = 4'd9,
    REQ_OBJBEG  = 4'd10,
    REQ_OBJEND  = 4'd11,
    REQ_ARRBEG  = 4'd12,
    REQ_ARREND  = 4'd13
  } req_kind_t;

  localparam logic [7:0] MK_NULL  = 8'h5A;
  localparam logic [7:0] MK_TRUE  = 8'h54;
  localparam logic [7:0] MK_FALSE = 8'h46;
  localparam logic [7:0] MK_I8    = 8'h69;
  localparam logic [7:0] MK_I16   = 8'h49;
  localparam logic [7:0] MK_I32   = 8'h6C;
  localparam logic [7:0] MK_I64   = 8'h4C;
  localparam logic [7:0] MK_F32   = 8'h64;
  localparam logic [7:0] MK_F64   = 8'h44;
  localparam logic [7:0] MK_STR   = 8'h53;
  localparam logic [7:0] MK_OBJB  = 8'h7B;
  localparam logic [7:0] MK_OBJE  = 8'h7D;
  localparam logic [7:0] MK_ARRB  = 8'h5B;
  localparam logic [7:0] MK_ARRE  = 8'h5D;

  // first byte to send in bits [7:0]
  typedef struct packed {
    logic [FRAME_W-1:0] bytes;
    logic [LEN_W-1:0]   len;
  } enc_frame_t;

endpackage
`default_nettype wire

FILE: rtl/core/ubjson_value_serializer.sv
// An accepted item is held in the frame register, then its bytes pass to the output register.
// One byte per cycle while out_tready is high; an item of n bytes (1 to 10) holds the byte
// sequencer, and the next item is taken in the cycle its last byte moves out.
// Kinds 14 and 15 produce no bytes.
// Reset (rst_n low, synchronous) empties the frame and output registers.
`default_nettype none
module ubjson_value_serializer
  import ubjv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] value
  input  wire logic [3:0]  in_tuser,   // [3:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast   // last_byte
);

  enc_frame_t frame;

  ubjv_encode u_encode (
    .req_type (in_tuser),
    .value    (in_tdata),
    .frame    (frame)
  );

  ubjv_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_tvalid),
    .load_ready (in_tready),
    .load_frame (frame),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: rtl/core/ubjv_encode.sv
`default_nettype none
module ubjv_encode
  import ubjv_pkg::*;
(
  input  wire logic [3:0]  req_type,
  input  wire logic [63:0] value,
  output enc_frame_t       frame
);

  logic [7:0]       marker;
  logic [LEN_W-1:0] nbytes;
  logic             is_str;
  logic             known;
  logic [63:0]      sel;
  logic [63:0]      payload_le;
  logic [5:0]       sh;

  always_comb begin
    marker = MK_NULL;
    nbytes = '0;
    is_str = 1'b0;
    known  = 1'b1;
    case (req_kind_t'(req_type))
      REQ_NULL:    marker = MK_NULL;
      REQ_BOOL:    marker = value[0] ? MK_TRUE : MK_FALSE;
      REQ_I8: begin
        marker = MK_I8;
        nbytes = 4'd1;
      end
      REQ_I16: begin
        marker = MK_I16;
        nbytes = 4'd2;
      end
      REQ_I32: begin
        marker = MK_I32;
        nbytes = 4'd4;
      end
      REQ_I64: begin
        marker = MK_I64;
        nbytes = 4'd8;
      end
      REQ_F32: begin
        if (value[30:23] != 8'hFF) begin
          marker = MK_F32;
          nbytes = 4'd4;
        end
      end
      REQ_F64: begin
        if (value[62:52] != 11'h7FF) begin
          marker = MK_F64;
          nbytes = 4'd8;
        end
      end
      REQ_STRHDR: begin
        is_str = 1'b1;
        if (value < 64'd127) begin
          marker = MK_I8;
          nbytes = 4'd1;
        end else if (value < 64'd32767) begin
          marker = MK_I16;
          nbytes = 4'd2;
        end else if (value < 64'd2147483647) begin
          marker = MK_I32;
          nbytes = 4'd4;
        end else begin
          marker = MK_I64;
          nbytes = 4'd8;
        end
      end
      REQ_STRCHAR: marker = value[7:0];
      REQ_OBJBEG:  marker = MK_OBJB;
      REQ_OBJEND:  marker = MK_OBJE;
      REQ_ARRBEG:  marker = MK_ARRB;
      REQ_ARREND:  marker = MK_ARRE;
      default:     known  = 1'b0;
    endcase
  end

  // left-align the used bytes, then reverse so the MSB goes out first
  assign sh  = {3'(4'd8 - nbytes), 3'b000};
  assign sel = (nbytes == 4'd0) ? 64'd0 : (value << sh);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      payload_le[8*k +: 8] = sel[63-8*k -: 8];
    end
  end

  always_comb begin
    if (is_str) begin
      frame.bytes = {payload_le, marker, MK_STR};
    end else begin
      frame.bytes = {8'd0, payload_le, marker};
    end
    if (known) begin
      frame.len = nbytes + (is_str ? 4'd2 : 4'd1);
    end else begin
      frame.len = '0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ubjv_serial.sv
`default_nettype none
module ubjv_serial
  import ubjv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load_valid,
  output logic            load_ready,
  input  wire enc_frame_t load_frame,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);

  logic [FRAME_W-1:0] data_r, data_nxt;
  logic [LEN_W-1:0]   left_r, left_nxt;
  logic               frame_vld_r, frame_vld_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [7:0]         byte_r;
  logic               last_r;
  logic               out_load;
  logic               frame_pop;
  logic               frame_done;
  logic               load_acc;

  assign out_load   = !out_vld_r || out_tready;
  assign frame_pop  = frame_vld_r && out_load;
  assign frame_done = frame_pop && (left_r == 4'd1);
  assign load_ready = !frame_vld_r || frame_done;
  assign load_acc   = load_valid && load_ready;

  always_comb begin
    data_nxt      = data_r;
    left_nxt      = left_r;
    frame_vld_nxt = frame_vld_r;
    if (frame_pop) begin
      data_nxt = data_r >> 8;
      left_nxt = left_r - 4'd1;
      if (frame_done) begin
        frame_vld_nxt = 1'b0;
      end
    end
    if (load_acc) begin
      data_nxt      = load_frame.bytes;
      left_nxt      = load_frame.len;
      frame_vld_nxt = (load_frame.len != '0);
    end
  end

  assign out_vld_nxt = out_load ? frame_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      frame_vld_r <= frame_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    left_r <= left_nxt;
    if (out_load) begin
      byte_r <= data_r[7:0];
      last_r <= (left_r == 4'd1);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

FILE: tb/ubjson_value_serializer_tb.sv
`default_nettype none
module ubjson_value_serializer_tb;
  import ubjv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned  N_RANDOM    = 250;
  localparam int unsigned  CYCLE_LIMIT = 400000;
  localparam int unsigned  DRAIN_WAIT  = 24;
  localparam logic [3:0]   REQ_SPARE_A = 4'd14;
  localparam logic [3:0]   REQ_SPARE_B = 4'd15;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
  } ser_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PERIODIC,
    RDY_SPARSE
  } rdy_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  ser_req_t    pending_reqs[$];
  enc_byte_t   expected_bytes[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_counted = 0;
  logic        in_taken = 1'b0;

  ubjson_value_serializer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  function automatic void put_byte(input logic [7:0] b, input logic last);
    enc_byte_t e;
    e.data = b;
    e.last = last;
    expected_bytes.insert(expected_bytes.size(), e);
  endfunction

  // marker, then n bytes of v most significant first
  function automatic void put_be(input logic [7:0] marker, input logic [63:0] v,
                                 input int n);
    put_byte(marker, 1'b0);
    for (int i = n - 1; i >= 0; i--) begin
      put_byte(v[i*8 +: 8], i == 0);
    end
  endfunction

  function automatic void encode_request(input logic [3:0] kind, input logic [63:0] v);
    case (kind)
      REQ_NULL:    put_byte(MK_NULL, 1'b1);
      REQ_BOOL:    put_byte(v[0] ? MK_TRUE : MK_FALSE, 1'b1);
      REQ_I8:      put_be(MK_I8, v, 1);
      REQ_I16:     put_be(MK_I16, v, 2);
      REQ_I32:     put_be(MK_I32, v, 4);
      REQ_I64:     put_be(MK_I64, v, 8);
      REQ_F32: begin
        if (v[30:23] == 8'hFF) put_byte(MK_NULL, 1'b1);
        else put_be(MK_F32, v, 4);
      end
      REQ_F64: begin
        if (v[62:52] == 11'h7FF) put_byte(MK_NULL, 1'b1);
        else put_be(MK_F64, v, 8);
      end
      REQ_STRHDR: begin
        put_byte(MK_STR, 1'b0);
        if (v < 64'd127) put_be(MK_I8, v, 1);
        else if (v < 64'd32767) put_be(MK_I16, v, 2);
        else if (v < 64'd2147483647) put_be(MK_I32, v, 4);
        else put_be(MK_I64, v, 8);
      end
      REQ_STRCHAR: put_byte(v[7:0], 1'b1);
      REQ_OBJBEG:  put_byte(MK_OBJB, 1'b1);
      REQ_OBJEND:  put_byte(MK_OBJE, 1'b1);
      REQ_ARRBEG:  put_byte(MK_ARRB, 1'b1);
      REQ_ARREND:  put_byte(MK_ARRE, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] rand_value(input logic [3:0] kind);
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case (kind)
      REQ_F32: if ($urandom_range(0, 3) == 0) v[30:23] = 8'hFF;
      REQ_F64: if ($urandom_range(0, 3) == 0) v[62:52] = 11'h7FF;
      REQ_STRHDR: begin
        case ($urandom_range(0, 4))
          0: v = 64'($urandom_range(0, 140));
          1: v = 64'd32760 + 64'($urandom_range(0, 14));
          2: v = 64'd2147483640 + 64'($urandom_range(0, 14));
          3: v = {32'd0, $urandom()};
          default: ;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic void add_req(input logic [3:0] kind, input logic [63:0] v);
    ser_req_t r;
    r.kind = kind;
    r.value = v;
    pending_reqs.insert(pending_reqs.size(), r);
    if (kind <= REQ_ARREND) n_counted++;
  endfunction

  // sender: bursts of random length, random gaps between
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk) begin : drive
    ser_req_t r;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= r.value;
        in_tuser <= r.kind;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  rdy_mode_t   rdy_mode = RDY_ALWAYS;
  int unsigned rdy_span = 0;
  int unsigned rdy_phase = 0;
  always @(negedge clk) begin
    if (rdy_span == 0) begin
      rdy_mode = rdy_mode_t'($urandom_range(0, 3));
      rdy_span = $urandom_range(20, 90);
    end else begin
      rdy_span--;
    end
    rdy_phase++;
    case (rdy_mode)
      RDY_ALWAYS:   out_tready <= 1'b1;
      RDY_COIN:     out_tready <= 1'($urandom_range(0, 1));
      RDY_PERIODIC: out_tready <= (rdy_phase % 5) != 0;
      default:      out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // monitor: prediction on input transaction, check on output transaction
  always @(posedge clk) begin : mon
    enc_byte_t e;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $realtime, cycles);
      $display("FAILURE");
      $finish;
    end else begin
      in_taken = rst_n && in_tvalid && in_tready;
      if (in_taken) encode_request(in_tuser, in_tdata);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction: expected none, actual data=%h last=%b",
                   $realtime, out_tdata, out_tlast);
        end else begin
          e = expected_bytes.pop_front();
          if (out_tdata !== e.data) begin
            errors++;
            $display("%0t data mismatch: expected %h, actual %h",
                     $realtime, e.data, out_tdata);
          end
          if (out_tlast !== e.last) begin
            errors++;
            $display("%0t last mismatch: expected %b, actual %b",
                     $realtime, e.last, out_tlast);
          end
        end
      end
    end
  end

  initial begin : stim
    logic [3:0]  kind;
    int unsigned len;
    int unsigned nvals;
    // directed
    add_req(REQ_NULL, 64'h0);
    add_req(REQ_BOOL, 64'h0);
    add_req(REQ_BOOL, 64'h1);
    add_req(REQ_BOOL, 64'hFFFF_FFFF_FFFF_FFFE);
    add_req(REQ_I8, 64'hDEAD_BEEF_0000_0080);
    add_req(REQ_I16, 64'h0000_0000_0000_8000);
    add_req(REQ_I32, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(REQ_I64, 64'h0102_0304_0506_0708);
    add_req(REQ_I64, 64'h8000_0000_0000_00FF);
    add_req(REQ_F32, 64'hFFFF_FFFF_3F80_0000);
    add_req(REQ_F32, 64'h0000_0000_7F80_0000);
    add_req(REQ_F32, 64'h0000_0000_FFC0_0001);
    add_req(REQ_F64, 64'h3FF0_0000_0000_0000);
    add_req(REQ_F64, 64'h7FF0_0000_0000_0000);
    add_req(REQ_F64, 64'hFFF8_0000_0000_0001);
    add_req(REQ_STRHDR, 64'd126);
    add_req(REQ_STRHDR, 64'd127);
    add_req(REQ_STRHDR, 64'd32766);
    add_req(REQ_STRHDR, 64'd32767);
    add_req(REQ_STRHDR, 64'd2147483646);
    add_req(REQ_STRHDR, 64'd2147483647);
    add_req(REQ_STRHDR, 64'h8000_0000_0000_0000);
    add_req(REQ_STRCHAR, 64'hFFFF_FFFF_FFFF_FF00);
    add_req(REQ_STRCHAR, 64'h0000_0000_0000_00FF);
    add_req(REQ_OBJBEG, 64'h0);
    add_req(REQ_OBJEND, 64'h0);
    add_req(REQ_ARRBEG, 64'h0);
    add_req(REQ_ARREND, 64'h0);
    add_req(REQ_SPARE_A, 64'h0);
    add_req(REQ_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
    n_counted = 0;
    // random: strings, containers with random content, single values, some noise
    while (n_counted < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(0, 6);
          add_req(REQ_STRHDR, 64'(len));
          for (int i = 0; i < len; i++) add_req(REQ_STRCHAR, rand_value(REQ_STRCHAR));
        end
        3, 4, 5, 6: begin
          kind = 4'($urandom_range(REQ_NULL, REQ_STRHDR));
          add_req(kind, rand_value(kind));
        end
        7, 8: begin
          kind = ($urandom_range(0, 1) == 0) ? REQ_OBJBEG : REQ_ARRBEG;
          add_req(kind, rand_value(kind));
          nvals = $urandom_range(0, 4);
          for (int i = 0; i < nvals; i++) begin
            if (kind == REQ_OBJBEG) begin
              add_req(REQ_STRHDR, 64'd1);
              add_req(REQ_STRCHAR, rand_value(REQ_STRCHAR));
            end
            add_req(4'($urandom_range(REQ_NULL, REQ_F64)), {$urandom(), $urandom()});
          end
          add_req((kind == REQ_OBJBEG) ? REQ_OBJEND : REQ_ARREND, rand_value(kind));
        end
        default: begin
          kind = 4'($urandom_range(0, 15));
          add_req(kind, rand_value(kind));
        end
      endcase
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_tvalid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      errors++;
      $display("%0t missing transactions: expected %0d more, actual 0",
               $realtime, expected_bytes.size());
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
